// File: rtl/dsv_pkg.sv
// Package for the date-time string validator: character codes, field
// positions, numeric limits and the month length function.
// No dependencies.
package dsv_pkg;

    localparam int unsigned DtLength    = 19;
    localparam int unsigned PosSaturate = 20;

    localparam logic [4:0] PosMonthLo  = 5'd3;
    localparam logic [4:0] PosColon0   = 5'd2;
    localparam logic [4:0] PosColon1   = 5'd5;
    localparam logic [4:0] PosSpace    = 5'd10;
    localparam logic [4:0] PosColon2   = 5'd13;
    localparam logic [4:0] PosColon3   = 5'd16;
    localparam logic [4:0] PosLast     = 5'(DtLength - 1);
    localparam logic [4:0] PosMax      = 5'(PosSaturate);
    localparam logic [4:0] PosYearLo   = 5'd6;
    localparam logic [4:0] PosHourLo   = 5'd11;
    localparam logic [4:0] PosMinuteLo = 5'd14;
    localparam logic [4:0] PosSecondLo = 5'd17;

    localparam logic [7:0] ChColon = 8'h3A;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;

    localparam logic [6:0] MonthMax  = 7'd12;
    localparam logic [6:0] HourMax   = 7'd23;
    localparam logic [6:0] MinSecMax = 7'd59;

    // floor(y / 25) == (y * DivMul25) >> DivShift25 for every 14-bit y.
    localparam logic [12:0] DivMul25   = 13'd5243;
    localparam int unsigned DivShift25 = 17;

    typedef logic [6:0]  t_val7;
    typedef logic [13:0] t_val14;

    function automatic logic [4:0] month_length(input t_val7 month, input logic leap);
        logic [4:0] len;
        case (month)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11: len = 5'd30;
            7'd2: len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/datetime_string_validator_core.sv
// Date-time string validator core: character-stream checker with an output register.
// Depends on dsv_pkg.
//
// The block takes one character per beat and gives one result beat, a single
// valid flag, for each beat marked last; the flag is 1 only for exactly 19
// characters in the form dd:MM:yyyy hh:mm:ss with a real calendar date
// (Gregorian leap years) and a time of at most 23:59:59. One character is
// taken every cycle unless input is stalled: each beat updates the position
// counter and field accumulators, and the verdict is loaded into the output
// register in that same cycle. Input is stalled only while a result waits in
// the output register and the downstream side stalls. After each last beat
// the position counter, failure flag and field accumulators are reset.
module datetime_string_validator_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_ch,
    input  logic                i_last,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_valid_res
);
    import dsv_pkg::*;

    logic [4:0] r_pos, n_pos;
    logic       r_failed, n_failed;
    t_val7      r_day, n_day;
    t_val7      r_month, n_month;
    t_val14     r_year, n_year;
    t_val7      r_hour, n_hour;
    t_val7      r_minute, n_minute;
    t_val7      r_second, n_second;
    logic [9:0] r_q25;
    logic       r_leap;
    logic       r_out_vld;
    logic       r_out_res;

    logic        w_accept;
    logic        w_digit;
    logic [3:0]  w_d;
    logic [26:0] w_prod;
    logic [13:0] w_q25x;
    logic        w_mul25;
    logic        w_res;

    function automatic t_val7 push7(input t_val7 acc, input logic [3:0] d);
        logic [10:0] sum;
        sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {7'd0, d};
        return sum[6:0];
    endfunction

    function automatic t_val14 push14(input t_val14 acc, input logic [3:0] d);
        logic [17:0] sum;
        sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {14'd0, d};
        return sum[13:0];
    endfunction

    assign o_stall  = r_out_vld & i_stall;
    assign w_accept = i_valid & ~o_stall;
    assign w_digit  = (i_ch >= ChZero) && (i_ch <= ChNine);
    assign w_d      = w_digit ? 4'(i_ch - ChZero) : 4'd0;

    // Year divided by 25 via reciprocal multiply; the year is settled many
    // beats before the last character, so two register stages are harmless.
    assign w_prod  = 27'(r_year) * 27'(DivMul25);
    assign w_q25x  = 14'({r_q25, 4'b0000} + {1'b0, r_q25, 3'b000} + {4'd0, r_q25});
    assign w_mul25 = (w_q25x == r_year);

    always_comb begin
        n_pos    = r_pos;
        n_failed = r_failed;
        n_day    = r_day;
        n_month  = r_month;
        n_year   = r_year;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        if (r_pos > PosLast) begin
            n_failed = 1'b1;
        end else if (r_pos == PosColon0 || r_pos == PosColon1 ||
                     r_pos == PosColon2 || r_pos == PosColon3) begin
            if (i_ch != ChColon) n_failed = 1'b1;
        end else if (r_pos == PosSpace) begin
            if (i_ch != ChSpace) n_failed = 1'b1;
        end else if (!w_digit) begin
            n_failed = 1'b1;
        end else if (r_pos < PosMonthLo) begin
            n_day = push7(r_day, w_d);
        end else if (r_pos < PosYearLo) begin
            n_month = push7(r_month, w_d);
        end else if (r_pos < PosHourLo) begin
            n_year = push14(r_year, w_d);
        end else if (r_pos < PosMinuteLo) begin
            n_hour = push7(r_hour, w_d);
        end else if (r_pos < PosSecondLo) begin
            n_minute = push7(r_minute, w_d);
        end else begin
            n_second = push7(r_second, w_d);
        end
        if (r_pos < PosMax) n_pos = r_pos + 5'd1;

        w_res = !n_failed && (r_pos == PosLast) &&
                (n_month >= 7'd1) && (n_month <= MonthMax) &&
                (n_day >= 7'd1) &&
                (n_day <= {2'b00, month_length(n_month, r_leap)}) &&
                (n_hour <= HourMax) && (n_minute <= MinSecMax) &&
                (n_second <= MinSecMax);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_failed  <= 1'b0;
            r_day     <= '0;
            r_month   <= '0;
            r_year    <= '0;
            r_hour    <= '0;
            r_minute  <= '0;
            r_second  <= '0;
            r_q25     <= '0;
            r_leap    <= 1'b0;
            r_out_vld <= 1'b0;
            r_out_res <= 1'b0;
        end else begin
            r_q25  <= w_prod[DivShift25 +: 10];
            // Leap: divisible by 4, and not by 100 unless also by 400.
            r_leap <= (r_year[1:0] == 2'b00) &&
                      (!w_mul25 || (r_year[3:0] == 4'b0000));
            if (w_accept && i_last) begin
                r_pos     <= '0;
                r_failed  <= 1'b0;
                r_day     <= '0;
                r_month   <= '0;
                r_year    <= '0;
                r_hour    <= '0;
                r_minute  <= '0;
                r_second  <= '0;
                r_out_vld <= 1'b1;
                r_out_res <= w_res;
            end else begin
                if (r_out_vld && !i_stall) r_out_vld <= 1'b0;
                if (w_accept) begin
                    r_pos    <= n_pos;
                    r_failed <= n_failed;
                    r_day    <= n_day;
                    r_month  <= n_month;
                    r_year   <= n_year;
                    r_hour   <= n_hour;
                    r_minute <= n_minute;
                    r_second <= n_second;
                end
            end
        end
    end

    assign o_valid     = r_out_vld;
    assign o_valid_res = r_out_res;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PosMax)
        else $error("position counter beyond saturation");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last) |=> (r_pos == '0 && !r_failed && r_year == '0 && o_valid))
        else $error("state not cleared after last beat");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid && i_stall)) |-> $past(w_accept && i_last))
        else $error("result appeared without a last beat");

    a_true_needs_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last && (r_pos != PosLast)) |=> !o_valid_res)
        else $error("wrong-length string reported valid");
endmodule
